/* rtl/imu_serial_frame_parser_macros.svh */
// ---------------------------------------------------------------------------
// imu_serial_frame_parser_macros
// Assertion macros used by the checker file of the frame parser.
// ---------------------------------------------------------------------------
`ifndef IMU_SERIAL_FRAME_PARSER_MACROS_SVH
`define IMU_SERIAL_FRAME_PARSER_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define ISFP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isfp checker: same-cycle implication failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define ISFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isfp checker: next-cycle implication failed");

`endif

/* rtl/isfp_pkg.sv */
// ---------------------------------------------------------------------------
// isfp_pkg
// Types and constants of the IMU serial frame parser.
// ---------------------------------------------------------------------------
package isfp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 10;

  localparam int unsigned WIN_BYTES = 9;
  localparam int unsigned FILL_W    = 4;

  localparam logic [7:0] SUM_SEED   = 8'h55;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic KIND_RATE  = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_FS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FS = 2'd1;

  localparam logic [11:0] RATE_FS_RESET  = 12'd2000;
  localparam logic [8:0]  ANGLE_FS_RESET = 9'd180;

  // rate: raw * fs * 314 / (32768 * 360 * 100)
  localparam int unsigned MULSEL_W = 21;
  localparam logic [MULSEL_W-1:0] RATE_NUM = 21'd314;
  localparam int unsigned REM_W = 31;
  localparam logic [REM_W-1:0] DEN_RATE   = 31'(32768 * 360 * 100);
  localparam logic [REM_W-1:0] HALF_RATE  = 31'(32768 * 360 * 50);
  localparam logic [REM_W-1:0] DEN_ANGLE  = 31'd32768;
  localparam logic [REM_W-1:0] HALF_ANGLE = 31'd16384;

  localparam int unsigned PROD_W     = 37;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned MPL_W      = 20;
  localparam int unsigned MUL_STEPS  = 20;
  localparam int unsigned SQRT_STEPS = 20;
  localparam int unsigned SREM_W     = 22;
  localparam int unsigned ROOT_W     = 21;

  localparam int unsigned SC_W  = 20;
  localparam int unsigned MAG_W = 18;
  localparam logic [31:0]     SC_POS_LIM = 32'd524287;
  localparam logic [31:0]     SC_NEG_LIM = 32'd524288;
  localparam logic [SC_W-1:0] SC_POS_SAT = 20'h7FFFF;
  localparam logic [SC_W-1:0] SC_NEG_SAT = 20'h80000;
  localparam logic [MAG_W-1:0] MAG_MAX   = 18'h3FFFF;

  localparam logic [1:0] K_LAST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MLOAD,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_STORE,
    ST_SLOAD,
    ST_SQR,
    ST_SQRT,
    ST_DONE
  } state_t;

endpackage

/* rtl/imu_serial_frame_parser.sv */
// ---------------------------------------------------------------------------
// imu_serial_frame_parser
// Eleven-byte sensor frame parser with sum checksum and fixed-point scaling.
// ---------------------------------------------------------------------------
// Use:
//   in_*  : one received byte per beat (tdata = rx_byte, tlast = end of buffer).
//   out_* : one beat per good rate or angle frame; tuser = frame kind.
//   cfg_* : register writes, always ready; index 0 rate full scale,
//           index 1 angle full scale; other indexes are dropped.
// Timing:
//   A byte that closes no frame is taken without a stall. A checksum byte that
//   closes a good frame starts the serial arithmetic, one bit or bit pair a
//   cycle through a shared shift-add multiplier, a restoring divider and a
//   square-root unit; in_tready is low meanwhile. The result beat follows
//   the arithmetic; a rate frame adds a squaring pass and the square root.
// Stall: the result sits in the output register; bytes are still taken
//   while it waits. A second result that finds it full waits in the final
//   state with in_tready low until out_tready.
// Reset: window empty, no skip pending, both full scales at their defaults.
// ---------------------------------------------------------------------------
module imu_serial_frame_parser
  import isfp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  logic                 in_tlast,   // last_in_buffer
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [15:0] raw_x, [31:16] raw_y, [47:32] raw_z, [67:48] scaled_x,
  // [87:68] scaled_y, [107:88] scaled_z, [125:108] rate_magnitude, [127:126] 0
  output logic [127:0]         out_tdata,
  output logic                 out_tuser,  // frame_kind
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]          cfg_data
);

  localparam int unsigned QW        = FRAC_BITS + 10;
  localparam int unsigned NW        = PROD_W + FRAC_BITS + 1;
  localparam int unsigned STEPS_MAX = (QW > MUL_STEPS) ? QW : MUL_STEPS;
  localparam int unsigned STEPW     = $clog2(STEPS_MAX);

  state_t state_r, state_nxt;

  logic [11:0]       rate_fs_r, rate_fs_nxt;
  logic [8:0]        angle_fs_r, angle_fs_nxt;
  logic [7:0]        win_r [WIN_BYTES];
  logic [7:0]        win_nxt [WIN_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              skip_r, skip_nxt;
  logic              kind_r, kind_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [STEPW-1:0]  step_r, step_nxt;
  logic [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [MPL_W-1:0]  mplier_r, mplier_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [SC_W-1:0]   sc_r [3];
  logic [SC_W-1:0]   sc_nxt [3];
  logic [SREM_W-1:0] srem_r, srem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [127:0]      out_data_r, out_data_nxt;

  logic                byte_acc;
  logic                frame_hit;
  logic                step_last;
  logic                out_load;
  logic [15:0]         raw_sel;
  logic [15:0]         abs_raw;
  logic [MULSEL_W-1:0] rate_mul;
  logic [MULSEL_W-1:0] mul_sel;
  logic [REM_W-1:0]    den_sel;
  logic [REM_W-1:0]    half_sel;
  logic [NW-1:0]       n_val;
  logic [REM_W:0]      div_t;
  logic [REM_W:0]      div_d;
  logic                div_ge;
  logic [31:0]         q_ext;
  logic [SC_W-1:0]     sc_clamped;
  logic [SC_W-1:0]     sc_cur;
  logic [SC_W-1:0]     abs_sc;
  logic [SREM_W+1:0]   sq_t;
  logic [SREM_W+1:0]   sq_trial;
  logic [SREM_W+1:0]   sq_d;
  logic                sq_ge;
  logic [MAG_W-1:0]    mag_val;

  // ---------------- decode ----------------
  always_comb begin
    byte_acc  = in_tvalid && in_tready;
    frame_hit = byte_acc && !skip_r && (fill_r == FILL_W'(WIN_BYTES)) &&
                ((win_r[0] == TYPE_RATE) || (win_r[0] == TYPE_ANGLE)) &&
                (sum_r == in_tdata);

    case (k_r)
      2'd0:    raw_sel = {win_r[2], win_r[1]};
      2'd1:    raw_sel = {win_r[4], win_r[3]};
      default: raw_sel = {win_r[6], win_r[5]};
    endcase
    abs_raw = raw_sel[15] ? (~raw_sel + 16'd1) : raw_sel;

    rate_mul = MULSEL_W'(rate_fs_r) * RATE_NUM;
    if (kind_r == KIND_ANGLE) begin
      mul_sel  = MULSEL_W'(angle_fs_r);
      den_sel  = DEN_ANGLE;
      half_sel = HALF_ANGLE;
    end else begin
      mul_sel  = rate_mul;
      den_sel  = DEN_RATE;
      half_sel = HALF_RATE;
    end

    n_val = {1'b0, acc_r[PROD_W-1:0], {FRAC_BITS{1'b0}}} + NW'(half_sel);

    div_t  = {rem_r, q_r[QW-1]};
    div_d  = div_t - {1'b0, den_sel};
    div_ge = (div_t >= {1'b0, den_sel});

    q_ext = 32'(q_r);
    if (!raw_sel[15]) begin
      sc_clamped = (q_ext > SC_POS_LIM) ? SC_POS_SAT : q_ext[SC_W-1:0];
    end else begin
      sc_clamped = (q_ext > SC_NEG_LIM) ? SC_NEG_SAT : (~q_ext[SC_W-1:0] + SC_W'(1));
    end

    sc_cur = sc_r[k_r];
    abs_sc = sc_cur[SC_W-1] ? (~sc_cur + SC_W'(1)) : sc_cur;

    sq_t     = {srem_r, acc_r[ACC_W-1:ACC_W-2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_d     = sq_t - sq_trial;
    sq_ge    = (sq_t >= sq_trial);

    if (kind_r == KIND_ANGLE) begin
      mag_val = '0;
    end else begin
      mag_val = (root_r > ROOT_W'(MAG_MAX)) ? MAG_MAX : root_r[MAG_W-1:0];
    end
  end

  // ---------------- FSM outputs ----------------
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
    case (state_r)
      ST_MUL, ST_SQR: step_last = (step_r == STEPW'(MUL_STEPS - 1));
      ST_DIV:         step_last = (step_r == STEPW'(QW - 1));
      ST_SQRT:        step_last = (step_r == STEPW'(SQRT_STEPS - 1));
      default:        step_last = 1'b0;
    endcase
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (frame_hit) state_nxt = ST_MLOAD;
      ST_MLOAD: state_nxt = ST_MUL;
      ST_MUL:   if (step_last) state_nxt = ST_DLOAD;
      ST_DLOAD: state_nxt = ST_DIV;
      ST_DIV:   if (step_last) state_nxt = ST_STORE;
      ST_STORE: begin
        if (k_r != K_LAST) state_nxt = ST_MLOAD;
        else if (kind_r == KIND_RATE) state_nxt = ST_SLOAD;
        else state_nxt = ST_DONE;
      end
      ST_SLOAD: state_nxt = ST_SQR;
      ST_SQR: begin
        if (step_last) state_nxt = (k_r == K_LAST) ? ST_SQRT : ST_SLOAD;
      end
      ST_SQRT:  if (step_last) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    rate_fs_nxt   = rate_fs_r;
    angle_fs_nxt  = angle_fs_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    skip_nxt      = skip_r;
    kind_nxt      = kind_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    sc_nxt        = sc_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_RATE_FS:  rate_fs_nxt  = cfg_data;
        CFG_ANGLE_FS: angle_fs_nxt = cfg_data[8:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (byte_acc) begin
          if (skip_r) begin
            skip_nxt = 1'b0;
          end else if (fill_r == FILL_W'(WIN_BYTES)) begin
            if (frame_hit) begin
              fill_nxt = '0;
              skip_nxt = 1'b1;
              sum_nxt  = SUM_SEED;
              kind_nxt = (win_r[0] == TYPE_ANGLE) ? KIND_ANGLE : KIND_RATE;
              k_nxt    = 2'd0;
            end else begin
              for (int i = 0; i < WIN_BYTES - 1; i++) win_nxt[i] = win_r[i+1];
              win_nxt[WIN_BYTES-1] = in_tdata;
              sum_nxt = sum_r - win_r[0] + in_tdata;
            end
          end else begin
            win_nxt[fill_r] = in_tdata;
            fill_nxt        = fill_r + FILL_W'(1);
            sum_nxt         = sum_r + in_tdata;
          end
          if (in_tlast) begin
            fill_nxt = '0;
            skip_nxt = 1'b0;
            sum_nxt  = SUM_SEED;
          end
        end
      end
      ST_MLOAD: begin
        mcand_nxt  = ACC_W'(mul_sel);
        mplier_nxt = MPL_W'(abs_raw);
        acc_nxt    = '0;
        step_nxt   = '0;
      end
      ST_MUL, ST_SQR: begin
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = {mcand_r[ACC_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MPL_W-1:1]};
        step_nxt   = step_r + STEPW'(1);
        if ((state_r == ST_SQR) && step_last) begin
          if (k_r != K_LAST) begin
            k_nxt = k_r + 2'd1;
          end else begin
            srem_nxt = '0;
            root_nxt = '0;
            step_nxt = '0;
          end
        end
      end
      ST_DLOAD: begin
        rem_nxt  = REM_W'(n_val[NW-1:QW]);
        q_nxt    = n_val[QW-1:0];
        step_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_d[REM_W-1:0] : div_t[REM_W-1:0];
        q_nxt    = {q_r[QW-2:0], div_ge};
        step_nxt = step_r + STEPW'(1);
      end
      ST_STORE: begin
        sc_nxt[k_r] = sc_clamped;
        k_nxt       = (k_r == K_LAST) ? 2'd0 : (k_r + 2'd1);
      end
      ST_SLOAD: begin
        mcand_nxt  = ACC_W'(abs_sc);
        mplier_nxt = abs_sc;
        if (k_r == 2'd0) acc_nxt = '0;
        step_nxt   = '0;
      end
      ST_SQRT: begin
        srem_nxt = sq_ge ? sq_d[SREM_W-1:0] : sq_t[SREM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], sq_ge};
        acc_nxt  = {acc_r[ACC_W-3:0], 2'b00};
        step_nxt = step_r + STEPW'(1);
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = kind_r;
      out_data_nxt  = {2'b00, mag_val, sc_r[2], sc_r[1], sc_r[0],
                       win_r[6], win_r[5], win_r[4], win_r[3], win_r[2], win_r[1]};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_fs_r   <= RATE_FS_RESET;
      angle_fs_r  <= ANGLE_FS_RESET;
      fill_r      <= '0;
      sum_r       <= SUM_SEED;
      skip_r      <= 1'b0;
      k_r         <= 2'd0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_fs_r   <= rate_fs_nxt;
      angle_fs_r  <= angle_fs_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      skip_r      <= skip_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    kind_r     <= kind_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    sc_r       <= sc_nxt;
    srem_r     <= srem_nxt;
    root_r     <= root_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

/* rtl/isfp_checker.sv */
// ---------------------------------------------------------------------------
// isfp_checker
// Port-level checks of the IMU serial frame parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "imu_serial_frame_parser_macros.svh"

module isfp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [7:0]   in_tdata,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tuser,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [1:0]   cfg_index,
  input logic [11:0]  cfg_data
);

  // stalled result beat holds
  `ISFP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // angle beats carry no magnitude
  `ISFP_ASSERT_IMPLY(a_angle_mag, out_tvalid && out_tuser, out_tdata[125:108] == 18'd0)

  // zero sample scales to zero, non-negative sample never scales negative
  `ISFP_ASSERT_IMPLY(a_zero_scale, out_tvalid && (out_tdata[15:0] == 16'd0), out_tdata[67:48] == 20'd0)
  `ISFP_ASSERT_IMPLY(a_sign_scale, out_tvalid && !out_tdata[15], !out_tdata[67])

  // the arithmetic lies between a closing byte and its result: no result straight after a byte beat
  `ISFP_ASSERT_NEXT(a_no_quick, in_tvalid && in_tready, !$rose(out_tvalid))

endmodule

bind imu_serial_frame_parser isfp_checker u_isfp_checker (.*);
